/* sv/smrg_pkg.sv */
// Shared types, codes and constants of the stepper move ramp generator.
`timescale 1ns / 1ps
`default_nettype none
package smrg_pkg;

  localparam int POS_W      = 20;
  localparam int HALF_W     = 13;
  localparam int LEN_W      = 16;
  localparam int MODE_W     = 3;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int EASE_W     = 8;
  localparam int EASE_IDX_W = 6;

  // Full scale of the ease table and its last index.
  localparam int EASE_FULL = 255;
  localparam int EASE_LAST = 63;

  localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ESTOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOME   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DISABLED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_MAX_LIM  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MIN_LIM  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_STEP = 3'd4;
  localparam logic [STAT_W-1:0] STAT_BUSY     = 3'd5;
  localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HALF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 3'd5;

  localparam logic [HALF_W-1:0] BASE_HALF_RST    = 13'd600;
  localparam logic [LEN_W-1:0]  ACCEL_LEN_RST    = 16'd300;
  localparam logic [LEN_W-1:0]  DECEL_LEN_RST    = 16'd300;
  localparam logic [POS_W-1:0]  TRAVEL_LIMIT_RST = 20'd28000;
  localparam logic [HALF_W-1:0] MIN_DELAY_RST    = 13'd20;
  localparam logic [HALF_W-1:0] MAX_DELAY_RST    = 13'd5000;

  // Half-cosine easing curve, 0 at the start of a ramp and 255 at its end.
  localparam logic [EASE_W-1:0] EASE_TABLE [64] = '{
    8'd0,   8'd0,   8'd1,   8'd1,   8'd3,   8'd4,   8'd6,   8'd8,
    8'd10,  8'd13,  8'd16,  8'd19,  8'd22,  8'd26,  8'd30,  8'd34,
    8'd38,  8'd43,  8'd48,  8'd53,  8'd58,  8'd64,  8'd69,  8'd75,
    8'd81,  8'd87,  8'd93,  8'd99,  8'd105, 8'd112, 8'd118, 8'd124,
    8'd131, 8'd137, 8'd143, 8'd150, 8'd156, 8'd162, 8'd168, 8'd174,
    8'd180, 8'd186, 8'd191, 8'd197, 8'd202, 8'd207, 8'd212, 8'd217,
    8'd221, 8'd225, 8'd229, 8'd233, 8'd236, 8'd239, 8'd242, 8'd245,
    8'd247, 8'd249, 8'd251, 8'd252, 8'd254, 8'd254, 8'd255, 8'd255
  };

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              step_pulse;
    logic              direction;
    logic [HALF_W-1:0] half_period;
    logic              move_done;
    logic [POS_W-1:0]  position;
    logic              motor_on;
    logic              busy_res;
  } res_t;

  // One ramp evaluation: ease position within a ramp of len steps, blended
  // from one half-period toward another.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic [HALF_W-1:0] from;
    logic [HALF_W-1:0] to;
  } ramp_req_t;

endpackage
`default_nettype wire

/* sv/smrg_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module smrg_div #(
  parameter int NW = 26,
  parameter int DW = 20,
  parameter int QB = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [QB-1:0]      quotient
);

  localparam int CW = (QB > 1) ? $clog2(QB) : 1;

  logic [DW-1:0] rem;
  logic [QB-1:0] dq;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diffv;
  logic          ge;
  logic [NW-1:0] hi;

  // The caller guarantees the quotient fits in QB bits, so the bits above
  // the low QB bits of the dividend are already below the divisor.
  assign hi    = dividend >> QB;
  assign trial = {rem, dq[QB-1]};
  assign diffv = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && !start && (cnt == '0);
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(QB - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(hi);
      dq  <= dividend[QB-1:0];
      den <= divisor;
    end else if (run) begin
      rem <= ge ? diffv[DW-1:0] : trial[DW-1:0];
      dq  <= {dq[QB-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule
`default_nettype wire

/* sv/smrg_ramp.sv */
// Ramp half-period sequencer: three passes through the serial divider.
`timescale 1ns / 1ps
`default_nettype none
module smrg_ramp #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire smrg_pkg::ramp_req_t          req,
  output logic                              done,
  output logic [smrg_pkg::HALF_W-1:0]       half
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int DW = smrg_pkg::POS_W;
  localparam int NW = DW + IW;
  localparam int QB = smrg_pkg::HALF_W;
  localparam int HW = smrg_pkg::HALF_W;

  typedef enum logic [4:0] {
    R_IDLE  = 5'b00001,
    R_MUL   = 5'b00010,
    R_LOAD  = 5'b00100,
    R_WAIT  = 5'b01000,
    R_SCALE = 5'b10000
  } ramp_state_t;

  typedef enum logic [2:0] {
    PH_IDX   = 3'b001,
    PH_EASE  = 3'b010,
    PH_BLEND = 3'b100
  } ramp_phase_t;

  ramp_state_t                    state;
  ramp_phase_t                    phase;
  smrg_pkg::ramp_req_t            rq;
  logic [NW-1:0]                  num;
  logic [DW-1:0]                  den;
  logic [HW-1:0]                  diff;
  logic                           falling;
  logic [smrg_pkg::EASE_W-1:0]    ease;
  logic                           div_done;
  logic [QB-1:0]                  quot;
  logic [smrg_pkg::EASE_IDX_W-1:0] tix;

  smrg_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == R_LOAD),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  // Resample the ramp index onto the stored table, clamped to its last entry.
  assign tix = (quot > QB'(smrg_pkg::EASE_LAST)) ? smrg_pkg::EASE_IDX_W'(smrg_pkg::EASE_LAST)
                                                 : quot[smrg_pkg::EASE_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      phase <= PH_IDX;
      done  <= 1'b0;
    end else begin
      done <= (state == R_WAIT) && div_done && (phase == PH_BLEND);
      case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_MUL;
          end
        end
        R_MUL: begin
          phase <= PH_IDX;
          state <= R_LOAD;
        end
        R_LOAD: begin
          state <= R_WAIT;
        end
        R_WAIT: begin
          if (div_done) begin
            case (phase)
              PH_IDX: begin
                phase <= PH_EASE;
                state <= R_LOAD;
              end
              PH_EASE: begin
                state <= R_SCALE;
              end
              default: begin
                state <= R_IDLE;
              end
            endcase
          end
        end
        R_SCALE: begin
          phase <= PH_BLEND;
          state <= R_LOAD;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (start) begin
          rq <= req;
        end
      end
      R_MUL: begin
        num     <= NW'(rq.pos) * NW'(TABLE_DEPTH - 1);
        den     <= rq.len;
        falling <= (rq.from >= rq.to);
        diff    <= (rq.from >= rq.to) ? (rq.from - rq.to) : (rq.to - rq.from);
      end
      R_WAIT: begin
        if (div_done) begin
          case (phase)
            PH_IDX: begin
              num <= NW'(quot) * NW'(smrg_pkg::EASE_LAST);
              den <= DW'(TABLE_DEPTH - 1);
            end
            PH_EASE: begin
              ease <= smrg_pkg::EASE_TABLE[tix];
            end
            default: begin
              half <= falling ? (rq.from - quot) : (rq.from + quot);
            end
          endcase
        end
      end
      R_SCALE: begin
        num <= NW'(diff) * NW'(ease);
        den <= DW'(smrg_pkg::EASE_FULL);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/stepper_move_ramp_generator.sv */
// Top level of the single-axis stepper move generator with S-curve ramps.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat gives exactly one result beat. Enable, start, e-stop,
// reset-position, idle ticks and cruise ticks pass from the result hold
// register into the output register, and no new beat is taken until they
// have moved there. A step tick inside the acceleration or deceleration
// ramp first waits for the ramp sequencer, with no new beat taken: the
// eased half-period needs three 13-bit passes through one bit-serial
// divider (ramp index, table resample, and the blend scaled by 1/255),
// each with load and hand-off, plus sequencing. A stalled output keeps
// the result in the hold register. A new input beat is taken while the
// previous result still waits in the output register. Configuration writes
// land at once and belong between moves.
module stepper_move_ramp_generator #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [smrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smrg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [smrg_pkg::MODE_W-1:0]         mode,
  input  wire logic                                enable_value,
  input  wire logic [smrg_pkg::POS_W-1:0]          steps,
  input  wire logic                                forward,
  input  wire logic [smrg_pkg::HALF_W-1:0]         cruise_half,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [smrg_pkg::STAT_W-1:0]              status,
  output logic                                     step_pulse,
  output logic                                     direction,
  output logic [smrg_pkg::HALF_W-1:0]              half_period,
  output logic                                     move_done,
  output logic [smrg_pkg::POS_W-1:0]               position,
  output logic                                     motor_on,
  output logic                                     busy_res
);

  localparam int PW = smrg_pkg::POS_W;
  localparam int HW = smrg_pkg::HALF_W;
  localparam int LW = smrg_pkg::LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_HOLD = 3'b100
  } top_state_t;

  top_state_t state;

  logic [HW-1:0] base_half;
  logic [LW-1:0] accel_len;
  logic [LW-1:0] decel_len;
  logic [PW-1:0] travel_limit;
  logic [HW-1:0] min_delay;
  logic [HW-1:0] max_delay;

  logic          enable_flag,     enable_flag_next;
  logic [PW-1:0] axis_position,   axis_position_next;
  logic          move_running,    move_running_next;
  logic [PW-1:0] move_total,      move_total_next;
  logic [PW-1:0] step_count,      step_count_next;
  logic          move_dir,        move_dir_next;
  logic [HW-1:0] move_cruise,     move_cruise_next;
  logic [PW-1:0] ramp_up_len,     ramp_up_len_next;
  logic [PW-1:0] ramp_down_start, ramp_down_start_next;

  smrg_pkg::res_t      res_hold, res_hold_next;
  smrg_pkg::res_t      res_out;
  smrg_pkg::ramp_req_t ramp_req, ramp_req_next;
  logic                ramp_go;
  logic                need_ramp;
  logic                ramp_done;
  logic [HW-1:0]       ramp_half;
  logic                accept;

  // Start-move preparation.
  logic [HW-1:0] cruise_lo;
  logic [HW-1:0] cruise_c;
  logic [PW-1:0] room;
  logic [PW-1:0] stp;
  logic [LW:0]   ramp_sum;
  logic          short_move;
  logic [PW-1:0] up_len;
  logic [PW-1:0] down_len;

  // Tick preparation.
  logic [PW-1:0] step_inc;
  logic          in_up;
  logic          in_down;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  assign cruise_lo  = (cruise_half < min_delay) ? min_delay : cruise_half;
  assign cruise_c   = (cruise_lo > max_delay) ? max_delay : cruise_lo;
  assign room       = forward ? (travel_limit - axis_position) : axis_position;
  assign stp        = (steps > room) ? room : steps;
  assign ramp_sum   = {1'b0, accel_len} + {1'b0, decel_len};
  assign short_move = (stp < PW'(ramp_sum));
  assign up_len     = short_move ? (stp >> 1) : PW'(accel_len);
  assign down_len   = short_move ? (stp - (stp >> 1)) : PW'(decel_len);

  assign step_inc = step_count + 1'b1;
  assign in_up    = (step_count < ramp_up_len);
  assign in_down  = (step_count >= ramp_down_start) && (move_total > ramp_down_start);

  always_comb begin
    enable_flag_next     = enable_flag;
    axis_position_next   = axis_position;
    move_running_next    = move_running;
    move_total_next      = move_total;
    step_count_next      = step_count;
    move_dir_next        = move_dir;
    move_cruise_next     = move_cruise;
    ramp_up_len_next     = ramp_up_len;
    ramp_down_start_next = ramp_down_start;
    ramp_req_next        = ramp_req;
    need_ramp            = 1'b0;
    res_hold_next        = '0;
    res_hold_next.status = smrg_pkg::STAT_OK;

    case (mode)
      smrg_pkg::MODE_ENABLE: begin
        enable_flag_next = enable_value;
        if (!enable_value) begin
          move_running_next = 1'b0;
        end
      end
      smrg_pkg::MODE_START: begin
        if (!enable_flag) begin
          res_hold_next.status = smrg_pkg::STAT_DISABLED;
        end else if (move_running) begin
          res_hold_next.status = smrg_pkg::STAT_BUSY;
        end else if (steps == '0) begin
          res_hold_next.status = smrg_pkg::STAT_BAD_STEP;
        end else if (forward && (axis_position >= travel_limit)) begin
          res_hold_next.status = smrg_pkg::STAT_MAX_LIM;
        end else if (!forward && (axis_position == '0)) begin
          res_hold_next.status = smrg_pkg::STAT_MIN_LIM;
        end else begin
          move_total_next      = stp;
          step_count_next      = '0;
          move_dir_next        = forward;
          move_cruise_next     = cruise_c;
          ramp_up_len_next     = up_len;
          ramp_down_start_next = stp - down_len;
          move_running_next    = 1'b1;
        end
      end
      smrg_pkg::MODE_TICK: begin
        if (!move_running) begin
          res_hold_next.status = smrg_pkg::STAT_IDLE;
        end else begin
          res_hold_next.step_pulse = 1'b1;
          axis_position_next = move_dir ? (axis_position + 1'b1) : (axis_position - 1'b1);
          step_count_next    = step_inc;
          if (step_inc >= move_total) begin
            res_hold_next.move_done = 1'b1;
            move_running_next       = 1'b0;
          end
          if (in_up) begin
            need_ramp          = 1'b1;
            ramp_req_next.pos  = step_count;
            ramp_req_next.len  = ramp_up_len;
            ramp_req_next.from = base_half;
            ramp_req_next.to   = move_cruise;
          end else if (in_down) begin
            need_ramp          = 1'b1;
            ramp_req_next.pos  = step_count - ramp_down_start;
            ramp_req_next.len  = move_total - ramp_down_start;
            ramp_req_next.from = move_cruise;
            ramp_req_next.to   = base_half;
          end else begin
            res_hold_next.half_period = move_cruise;
          end
        end
      end
      smrg_pkg::MODE_ESTOP: begin
        enable_flag_next  = 1'b0;
        move_running_next = 1'b0;
      end
      smrg_pkg::MODE_HOME: begin
        if (move_running) begin
          res_hold_next.status = smrg_pkg::STAT_BUSY;
        end else begin
          axis_position_next = '0;
        end
      end
      default: begin
      end
    endcase

    res_hold_next.direction = move_dir_next;
    res_hold_next.position  = axis_position_next;
    res_hold_next.motor_on  = enable_flag_next;
    res_hold_next.busy_res  = move_running_next;
  end

  smrg_ramp #(.TABLE_DEPTH(TABLE_DEPTH)) u_ramp (
    .clk   (clk),
    .rst   (rst),
    .start (ramp_go),
    .req   (ramp_req),
    .done  (ramp_done),
    .half  (ramp_half)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_half    <= smrg_pkg::BASE_HALF_RST;
      accel_len    <= smrg_pkg::ACCEL_LEN_RST;
      decel_len    <= smrg_pkg::DECEL_LEN_RST;
      travel_limit <= smrg_pkg::TRAVEL_LIMIT_RST;
      min_delay    <= smrg_pkg::MIN_DELAY_RST;
      max_delay    <= smrg_pkg::MAX_DELAY_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        smrg_pkg::CFG_BASE_HALF:    base_half    <= cfg_data[HW-1:0];
        smrg_pkg::CFG_ACCEL_LEN:    accel_len    <= cfg_data[LW-1:0];
        smrg_pkg::CFG_DECEL_LEN:    decel_len    <= cfg_data[LW-1:0];
        smrg_pkg::CFG_TRAVEL_LIMIT: travel_limit <= cfg_data[PW-1:0];
        smrg_pkg::CFG_MIN_DELAY:    min_delay    <= cfg_data[HW-1:0];
        smrg_pkg::CFG_MAX_DELAY:    max_delay    <= cfg_data[HW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_flag     <= 1'b0;
      axis_position   <= '0;
      move_running    <= 1'b0;
      move_total      <= '0;
      step_count      <= '0;
      move_dir        <= 1'b0;
      move_cruise     <= '0;
      ramp_up_len     <= '0;
      ramp_down_start <= '0;
    end else if (accept) begin
      enable_flag     <= enable_flag_next;
      axis_position   <= axis_position_next;
      move_running    <= move_running_next;
      move_total      <= move_total_next;
      step_count      <= step_count_next;
      move_dir        <= move_dir_next;
      move_cruise     <= move_cruise_next;
      ramp_up_len     <= ramp_up_len_next;
      ramp_down_start <= ramp_down_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ramp_go   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ramp_go <= accept && need_ramp;
      if ((state == ST_HOLD) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= need_ramp ? ST_CALC : ST_HOLD;
          end
        end
        ST_CALC: begin
          if (ramp_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hold <= res_hold_next;
      ramp_req <= ramp_req_next;
    end else if ((state == ST_CALC) && ramp_done) begin
      res_hold.half_period <= ramp_half;
    end
    if ((state == ST_HOLD) && (!out_valid || out_ready)) begin
      res_out <= res_hold;
    end
  end

  assign status      = res_out.status;
  assign step_pulse  = res_out.step_pulse;
  assign direction   = res_out.direction;
  assign half_period = res_out.half_period;
  assign move_done   = res_out.move_done;
  assign position    = res_out.position;
  assign motor_on    = res_out.motor_on;
  assign busy_res    = res_out.busy_res;

endmodule
`default_nettype wire
